// ===== rtl/timestamped_history_lookup_macros.svh =====
// Assertion macros for the timestamped history lookup block.
// Expects clk and arst_n in the scope where they are used.
`ifndef TIMESTAMPED_HISTORY_LOOKUP_MACROS_SVH
`define TIMESTAMPED_HISTORY_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define THL_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define THL_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/thl_pkg.sv =====
// Shared types and constants for the timestamped history lookup block.
// No dependencies.
`default_nettype none
package thl_pkg;

	localparam int DEPTH_DEF       = 64;
	localparam int PARENT_BITS_DEF = 16;
	localparam int STAMP_W         = 63;
	localparam int DATA_W          = 64;
	localparam int PARENT_W        = 16;
	localparam int RATIO_W         = 16;
	localparam int COUNT_W         = 7;
	localparam logic [STAMP_W-1:0] MAX_AGE_RST = 63'd10000000000;

	// action codes
	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_LOOKUP = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	// result status codes
	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_TOO_OLD  = 3'd1,
		STS_REPEAT   = 3'd2,
		STS_EMPTY    = 3'd3,
		STS_SINGLE   = 3'd4,
		STS_FUTURE   = 3'd5,
		STS_PAST     = 3'd6,
		STS_OVERFLOW = 3'd7
	} status_t;

endpackage
`default_nettype wire

// ===== rtl/thl_div.sv =====
// Bit-serial restoring divider for the Q0.16 interpolation ratio.
// Depends on thl_pkg.
`default_nettype none
module thl_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [thl_pkg::STAMP_W-1:0]  num,
	input  wire logic [thl_pkg::STAMP_W-1:0]  den,
	output logic                              done,
	output logic [thl_pkg::RATIO_W-1:0]       quot
);
	localparam int NW = thl_pkg::STAMP_W + 1;
	localparam int CW = $clog2(thl_pkg::RATIO_W + 1);

	logic [NW-1:0]                rem_q;
	logic [NW-1:0]                den_q;
	logic [thl_pkg::RATIO_W-1:0]  quot_q;
	logic [CW-1:0]                cnt_q;
	logic                         run_q;
	logic                         done_q;
	logic [NW-1:0]                rem_sh;
	logic                         fits;

	// one quotient bit per cycle
	assign rem_sh = {rem_q[NW-2:0], 1'b0};
	assign fits   = rem_sh >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// done pulses at once when the ratio is zero, else after the last bit
			done_q <= start ? ((num >= den) || (den == '0))
				: (run_q && (cnt_q == CW'(thl_pkg::RATIO_W - 1)));
			if (start) begin
				// fraction must be below one, otherwise ratio is zero
				run_q <= !((num >= den) || (den == '0));
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(thl_pkg::RATIO_W - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			den_q  <= {1'b0, den};
			quot_q <= '0;
		end else if (run_q) begin
			rem_q  <= fits ? (rem_sh - den_q) : rem_sh;
			quot_q <= {quot_q[thl_pkg::RATIO_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule
`default_nettype wire

// ===== rtl/timestamped_history_lookup.sv =====
// Timestamped history lookup. Keeps up to DEPTH entries (stamp, parent id, payload)
// sorted newest first in a single-port-read memory and walks it one entry per cycle
// under a small sequencer. A placed insert scans for its slot, prunes aged entries
// from the old end, shifts the older entries up and writes the new one; pruned
// entries are not shifted. A rejected insert ends earlier. A bracketing lookup
// scans for the pair and then waits on the bit-serial ratio divider; other lookup
// outcomes end sooner. The memory's single read port and the one-bit-per-cycle
// divider set the run time. One item is worked at a time; s_axis_tready is high
// only while the sequencer is idle, and a finished result sits in an output register
// so the next beat can be taken while it waits.
// Depends on thl_pkg, thl_div and timestamped_history_lookup_macros.svh.
`default_nettype none
`include "timestamped_history_lookup_macros.svh"
module timestamped_history_lookup #(
	parameter int DEPTH       = thl_pkg::DEPTH_DEF,
	parameter int PARENT_BITS = thl_pkg::PARENT_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// max_age register write
	input  wire logic          max_age_we,
	input  wire logic [62:0]   max_age_wdata,
	// input stream
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	input  wire logic [143:0]  s_axis_tdata,  // time_stamp[62:0], parent_id[78:63],
	                                          // entry_data[142:79], zero pad[143]
	input  wire logic [1:0]    s_axis_tuser,  // action[1:0]
	// result stream
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	output logic [295:0]       m_axis_tdata,  // match_count[1:0], older_stamp[64:2],
	                                          // older_parent[80:65], older_data[144:81],
	                                          // newer_stamp[207:145], newer_data[271:208],
	                                          // ratio[287:272], entry_count[294:288],
	                                          // zero pad[295]
	output logic [2:0]         m_axis_tuser   // status[2:0]
);
	localparam int SW = thl_pkg::STAMP_W;
	localparam int DW = thl_pkg::DATA_W;
	localparam int PB = PARENT_BITS;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [12:0] {
		ST_IDLE     = 13'b0000000000001,
		ST_SCAN     = 13'b0000000000010,
		ST_PRUNE_RD = 13'b0000000000100,
		ST_PRUNE    = 13'b0000000001000,
		ST_FIT      = 13'b0000000010000,
		ST_SHIFT_RD = 13'b0000000100000,
		ST_SHIFT    = 13'b0000001000000,
		ST_WRITE    = 13'b0000010000000,
		ST_L0       = 13'b0000100000000,
		ST_LLAST    = 13'b0001000000000,
		ST_LSCAN    = 13'b0010000000000,
		ST_DIV      = 13'b0100000000000,
		ST_DONE     = 13'b1000000000000
	} state_t;

	// entry memory
	logic [SW-1:0] stamp_mem  [DEPTH];
	logic [PB-1:0] parent_mem [DEPTH];
	logic [DW-1:0] data_mem   [DEPTH];

	logic [SW-1:0] rd_stamp_q;
	logic [PB-1:0] rd_parent_q;
	logic [DW-1:0] rd_data_q;
	logic [CW-1:0] raddr_full;
	logic          we;
	logic [AW-1:0] waddr;
	logic [SW-1:0] wstamp;
	logic [PB-1:0] wparent;
	logic [DW-1:0] wdata;

	// control and item registers
	state_t        state_q;
	logic [SW-1:0] max_age_q;
	logic [CW-1:0] held_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] k_q;
	logic [SW-1:0] t_q;
	logic [PB-1:0] par_q;
	logic [DW-1:0] dat_q;
	logic [SW-1:0] newest_q;
	logic [SW-1:0] prev_stamp_q;
	logic [PB-1:0] prev_parent_q;
	logic [DW-1:0] prev_data_q;

	// pending result
	logic [2:0]    res_status_q;
	logic [1:0]    res_mc_q;
	logic [SW-1:0] res_os_q;
	logic [15:0]   res_op_q;
	logic [DW-1:0] res_od_q;
	logic [SW-1:0] res_ns_q;
	logic [DW-1:0] res_nd_q;
	logic [15:0]   res_ratio_q;

	// output register
	logic          out_valid_q;
	logic [295:0]  out_data_q;
	logic [2:0]    out_user_q;

	logic          in_acc;
	logic          div_start;
	logic          div_done;
	logic [15:0]   div_quot;
	logic [SW:0]   old_limit;
	logic [SW:0]   keep_limit;
	logic          out_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	// wide compares for age checks (sums of two stamps fit in 64 bits)
	assign old_limit  = {1'b0, t_q} + {1'b0, max_age_q};
	assign keep_limit = {1'b0, rd_stamp_q} + {1'b0, max_age_q};

	// read address per state
	always_comb begin
		unique case (state_q)
			ST_IDLE:     raddr_full = '0;
			ST_SCAN:     raddr_full = idx_q + 1'b1;
			ST_PRUNE_RD: raddr_full = held_q - 1'b1;
			ST_PRUNE:    raddr_full = k_q - CW'(2);
			ST_SHIFT_RD: raddr_full = held_q - 1'b1;
			ST_SHIFT:    raddr_full = k_q - CW'(2);
			ST_L0:       raddr_full = held_q - 1'b1;
			ST_LLAST:    raddr_full = CW'(1);
			ST_LSCAN:    raddr_full = idx_q + 1'b1;
			default:     raddr_full = '0;
		endcase
	end

	// write port: shift moves an entry up, write places the new one
	always_comb begin
		we      = 1'b0;
		waddr   = k_q[AW-1:0];
		wstamp  = rd_stamp_q;
		wparent = rd_parent_q;
		wdata   = rd_data_q;
		if (state_q == ST_SHIFT) begin
			we = 1'b1;
		end else if (state_q == ST_WRITE) begin
			we      = 1'b1;
			waddr   = i_q[AW-1:0];
			wstamp  = t_q;
			wparent = par_q;
			wdata   = dat_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			stamp_mem[waddr]  <= wstamp;
			parent_mem[waddr] <= wparent;
			data_mem[waddr]   <= wdata;
		end
		rd_stamp_q  <= stamp_mem[raddr_full[AW-1:0]];
		rd_parent_q <= parent_mem[raddr_full[AW-1:0]];
		rd_data_q   <= data_mem[raddr_full[AW-1:0]];
	end

	// max_age register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= thl_pkg::MAX_AGE_RST;
		end else if (max_age_we) begin
			max_age_q <= max_age_wdata;
		end
	end

	assign div_start = (state_q == ST_LSCAN)
		&& !((idx_q < held_q - 1'b1) && (rd_stamp_q > t_q))
		&& (rd_parent_q == prev_parent_q);

	thl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (t_q - rd_stamp_q),
		.den    (prev_stamp_q - rd_stamp_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q  <= '0;
			idx_q   <= '0;
			i_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (in_acc) begin
						unique case (thl_pkg::action_t'(s_axis_tuser))
							thl_pkg::ACT_INSERT: state_q <= ST_SCAN;
							thl_pkg::ACT_LOOKUP: state_q <= ST_L0;
							thl_pkg::ACT_CLEAR: begin
								held_q  <= '0;
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					priority if (idx_q == '0 && held_q != '0
							&& {1'b0, rd_stamp_q} > old_limit) begin
						state_q <= ST_DONE;
					end else if (idx_q < held_q && rd_stamp_q > t_q) begin
						idx_q <= idx_q + 1'b1;
					end else if (idx_q < held_q && rd_stamp_q == t_q) begin
						state_q <= ST_DONE;
					end else begin
						i_q     <= idx_q;
						state_q <= ST_PRUNE_RD;
					end
				end
				ST_PRUNE_RD: begin
					k_q     <= held_q;
					state_q <= ST_PRUNE;
				end
				ST_PRUNE: begin
					if (k_q > i_q && keep_limit < {1'b0, newest_q}) begin
						k_q <= k_q - 1'b1;
					end else begin
						state_q <= ST_FIT;
					end
				end
				ST_FIT: begin
					priority if (k_q >= CW'(DEPTH) && i_q >= CW'(DEPTH)) begin
						held_q  <= k_q;
						state_q <= ST_DONE;
					end else if (k_q >= CW'(DEPTH)) begin
						held_q  <= CW'(DEPTH - 1);
						state_q <= ST_SHIFT_RD;
					end else begin
						held_q  <= k_q;
						state_q <= ST_SHIFT_RD;
					end
				end
				ST_SHIFT_RD: begin
					k_q     <= held_q;
					state_q <= (held_q > i_q) ? ST_SHIFT : ST_WRITE;
				end
				ST_SHIFT: begin
					k_q <= k_q - 1'b1;
					if (!(k_q - 1'b1 > i_q)) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					held_q  <= held_q + 1'b1;
					state_q <= ST_DONE;
				end
				ST_L0: begin
					priority if (held_q == '0 || t_q == '0 || held_q == CW'(1)
							|| t_q >= rd_stamp_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_LLAST;
					end
				end
				ST_LLAST: begin
					if (t_q <= rd_stamp_q) begin
						state_q <= ST_DONE;
					end else begin
						idx_q   <= CW'(1);
						state_q <= ST_LSCAN;
					end
				end
				ST_LSCAN: begin
					if ((idx_q < held_q - 1'b1) && (rd_stamp_q > t_q)) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= div_start ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item fields and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					t_q          <= s_axis_tdata[62:0];
					par_q        <= PB'(s_axis_tdata[78:63]);
					dat_q        <= s_axis_tdata[142:79];
					res_status_q <= thl_pkg::STS_OK;
					res_mc_q     <= '0;
					res_os_q     <= '0;
					res_op_q     <= '0;
					res_od_q     <= '0;
					res_ns_q     <= '0;
					res_nd_q     <= '0;
					res_ratio_q  <= '0;
				end
			end
			ST_SCAN: begin
				// newest stamp once the entry is placed
				if (idx_q == '0) begin
					newest_q <= (held_q != '0 && rd_stamp_q > t_q) ? rd_stamp_q : t_q;
				end
				priority if (idx_q == '0 && held_q != '0
						&& {1'b0, rd_stamp_q} > old_limit) begin
					res_status_q <= thl_pkg::STS_TOO_OLD;
				end else if (idx_q < held_q && rd_stamp_q == t_q) begin
					res_status_q <= thl_pkg::STS_REPEAT;
				end else begin
					res_status_q <= thl_pkg::STS_OK;
				end
			end
			ST_FIT: begin
				if (k_q >= CW'(DEPTH)) begin
					res_status_q <= thl_pkg::STS_OVERFLOW;
				end
			end
			ST_L0: begin
				prev_stamp_q  <= rd_stamp_q;
				prev_parent_q <= rd_parent_q;
				prev_data_q   <= rd_data_q;
				priority if (held_q == '0) begin
					res_status_q <= thl_pkg::STS_EMPTY;
				end else if (t_q == '0 || t_q == rd_stamp_q) begin
					res_mc_q <= 2'd1;
					res_os_q <= rd_stamp_q;
					res_op_q <= 16'(rd_parent_q);
					res_od_q <= rd_data_q;
				end else if (held_q == CW'(1)) begin
					res_status_q <= thl_pkg::STS_SINGLE;
				end else if (t_q > rd_stamp_q) begin
					res_status_q <= thl_pkg::STS_FUTURE;
				end else begin
					// below the newest: the oldest entry decides next
					res_status_q <= thl_pkg::STS_OK;
				end
			end
			ST_LLAST: begin
				if (t_q == rd_stamp_q) begin
					res_mc_q <= 2'd1;
					res_os_q <= rd_stamp_q;
					res_op_q <= 16'(rd_parent_q);
					res_od_q <= rd_data_q;
				end else if (t_q < rd_stamp_q) begin
					res_status_q <= thl_pkg::STS_PAST;
				end
			end
			ST_LSCAN: begin
				if ((idx_q < held_q - 1'b1) && (rd_stamp_q > t_q)) begin
					prev_stamp_q  <= rd_stamp_q;
					prev_parent_q <= rd_parent_q;
					prev_data_q   <= rd_data_q;
				end else begin
					res_os_q <= rd_stamp_q;
					res_op_q <= 16'(rd_parent_q);
					res_od_q <= rd_data_q;
					if (div_start) begin
						res_mc_q <= 2'd2;
						res_ns_q <= prev_stamp_q;
						res_nd_q <= prev_data_q;
					end else begin
						// parents differ: fall back to the older entry
						res_mc_q <= 2'd1;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					res_ratio_q <= div_quot;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_user_q <= res_status_q;
			out_data_q <= {1'b0, thl_pkg::COUNT_W'(held_q), res_ratio_q, res_nd_q,
				res_ns_q, res_od_q, res_op_q, res_os_q, res_mc_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// checks
	`THL_ASSERT_NOW(a_held_bound, state_q == ST_IDLE, held_q <= CW'(DEPTH),
		"held entry count above depth")
	`THL_ASSERT_NEXT(a_accept_busy, in_acc, state_q != ST_IDLE,
		"sequencer still idle after accepting a beat")
	`THL_ASSERT_NOW(a_pair_ok, out_valid_q && out_data_q[1:0] == 2'd2,
		out_user_q == thl_pkg::STS_OK, "bracketing pair with error status")
	`THL_ASSERT_NOW(a_div_state, div_done, state_q == ST_DIV,
		"divider finished outside ratio wait")
endmodule
`default_nettype wire

// ===== sim/timestamped_history_lookup_test.sv =====
// Self-checking testbench for timestamped_history_lookup: the insert, lookup and clear
// stream is scored against an in-bench model of the sorted history buffer.
// Depends on thl_pkg and the block's RTL.
`timescale 1ns / 1ps
module timestamped_history_lookup_test;

	localparam int DEPTH = 64;
	localparam logic [62:0] STAMP_MAX = {63{1'b1}};
	localparam int DRAIN_CYCLES = 300;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [1:0]  act;
		logic [62:0] stamp;
		logic [15:0] parent;
		logic [63:0] data;
		bit          hold;   // wait for all results before this beat
	} req_t;

	typedef struct {
		logic [2:0]  status;
		logic [1:0]  match_count;
		logic [62:0] older_stamp;
		logic [15:0] older_parent;
		logic [63:0] older_data;
		logic [62:0] newer_stamp;
		logic [63:0] newer_data;
		logic [15:0] ratio;
		logic [6:0]  entry_count;
	} res_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          max_age_we = 1'b0;
	logic [62:0]   max_age_wdata = '0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [143:0]  s_axis_tdata = '0;
	logic [1:0]    s_axis_tuser = '0;
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [295:0]  m_axis_tdata;
	logic [2:0]    m_axis_tuser;

	timestamped_history_lookup i_dut (
		.clk(clk), .arst_n(arst_n),
		.max_age_we(max_age_we), .max_age_wdata(max_age_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	// model state of the history buffer
	logic [62:0] hist_stamp [DEPTH];
	logic [15:0] hist_parent [DEPTH];
	logic [63:0] hist_data [DEPTH];
	int          hist_count = 0;
	logic [62:0] model_age = thl_pkg::MAX_AGE_RST;

	req_t        pending_beats [$];
	res_t        expected_results [$];
	int          fails = 0;
	bit          calm = 0;
	longint      cycles = 0;
	logic [62:0] recent_stamps [$];

	initial begin
		for (int n = 0; n < DEPTH; n++) begin
			hist_stamp[n] = '0;
			hist_parent[n] = '0;
			hist_data[n] = '0;
		end
	end

	initial begin
		forever #5 clk = ~clk;
	end

	// bit-serial Q0.16 quotient, zero when out of range
	function automatic logic [15:0] q16_frac(logic [63:0] num, logic [63:0] den);
		logic [63:0] r;
		logic [15:0] q;
		r = num;
		q = '0;
		if (den == 0 || num >= den) return '0;
		for (int b = 0; b < 16; b++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [2:0] history_insert(logic [62:0] st, logic [15:0] par,
			logic [63:0] dat);
		int i, k;
		logic [63:0] newest;
		logic [2:0] sts;
		i = 0;
		sts = thl_pkg::STS_OK;
		if (hist_count > 0 && {1'b0, hist_stamp[0]} > {1'b0, st} + {1'b0, model_age})
			return thl_pkg::STS_TOO_OLD;
		while (i < hist_count && hist_stamp[i] > st) i++;
		if (i < hist_count && hist_stamp[i] == st) return thl_pkg::STS_REPEAT;
		newest = (i == 0) ? {1'b0, st} : {1'b0, hist_stamp[0]};
		k = hist_count;
		while (k > i && {1'b0, hist_stamp[k-1]} + {1'b0, model_age} < newest) k--;
		hist_count = k;
		if (hist_count >= DEPTH) begin
			if (i >= DEPTH) return thl_pkg::STS_OVERFLOW;
			hist_count = DEPTH - 1;
			sts = thl_pkg::STS_OVERFLOW;
		end
		for (int j = hist_count; j > i; j--) begin
			hist_stamp[j] = hist_stamp[j-1];
			hist_parent[j] = hist_parent[j-1];
			hist_data[j] = hist_data[j-1];
		end
		hist_stamp[i] = st;
		hist_parent[i] = par;
		hist_data[i] = dat;
		hist_count++;
		return sts;
	endfunction

	function automatic void take_older(ref res_t r, input int idx);
		r.older_stamp = hist_stamp[idx];
		r.older_parent = hist_parent[idx];
		r.older_data = hist_data[idx];
	endfunction

	function automatic void history_lookup(logic [62:0] t, ref res_t r);
		int n, i;
		n = hist_count;
		if (n == 0) begin
			r.status = thl_pkg::STS_EMPTY;
		end else if (t == 0) begin
			r.match_count = 1;
			take_older(r, 0);
		end else if (n == 1) begin
			if (hist_stamp[0] == t) begin
				r.match_count = 1;
				take_older(r, 0);
			end else begin
				r.status = thl_pkg::STS_SINGLE;
			end
		end else if (t == hist_stamp[0]) begin
			r.match_count = 1;
			take_older(r, 0);
		end else if (t == hist_stamp[n-1]) begin
			r.match_count = 1;
			take_older(r, n - 1);
		end else if (t > hist_stamp[0]) begin
			r.status = thl_pkg::STS_FUTURE;
		end else if (t < hist_stamp[n-1]) begin
			r.status = thl_pkg::STS_PAST;
		end else begin
			i = 1;
			while (i < n - 1 && hist_stamp[i] > t) i++;
			take_older(r, i);
			if (hist_parent[i] != hist_parent[i-1]) begin
				r.match_count = 1;
			end else begin
				r.match_count = 2;
				r.newer_stamp = hist_stamp[i-1];
				r.newer_data = hist_data[i-1];
				r.ratio = q16_frac({1'b0, t} - {1'b0, hist_stamp[i]},
					{1'b0, hist_stamp[i-1]} - {1'b0, hist_stamp[i]});
			end
		end
	endfunction

	function automatic res_t history_step(req_t q);
		res_t r;
		r = '{default: '0};
		case (q.act)
			thl_pkg::ACT_INSERT: r.status = history_insert(q.stamp, q.parent, q.data);
			thl_pkg::ACT_LOOKUP: history_lookup(q.stamp, r);
			thl_pkg::ACT_CLEAR:  hist_count = 0;
			default: ;
		endcase
		r.entry_count = hist_count[6:0];
		return r;
	endfunction

	// input driver
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(history_step('{s_axis_tuser, s_axis_tdata[62:0],
					s_axis_tdata[78:63], s_axis_tdata[142:79], 1'b0}));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_beats.size() > 0 && (calm || $urandom_range(0, 99) >= 29) &&
						(!pending_beats[0].hold || expected_results.size() == 0)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= pending_beats[0].act;
					s_axis_tdata <= {1'b0, pending_beats[0].data, pending_beats[0].parent,
						pending_beats[0].stamp};
					void'(pending_beats.pop_front());
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			$display("%0t: mismatch %s expected %h actual %h", $time, name, e, a);
			fails++;
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		res_t e;
		if (arst_n) begin
			m_axis_tready <= calm || $urandom_range(0, 99) >= 29;
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat %h / %h", $time, m_axis_tuser,
						m_axis_tdata);
					fails++;
				end else begin
					e = expected_results.pop_front();
					check_field("status", e.status, m_axis_tuser);
					check_field("match_count", e.match_count, m_axis_tdata[1:0]);
					check_field("older_stamp", e.older_stamp, m_axis_tdata[64:2]);
					check_field("older_parent", e.older_parent, m_axis_tdata[80:65]);
					check_field("older_data", e.older_data, m_axis_tdata[144:81]);
					check_field("newer_stamp", e.newer_stamp, m_axis_tdata[207:145]);
					check_field("newer_data", e.newer_data, m_axis_tdata[271:208]);
					check_field("ratio", e.ratio, m_axis_tdata[287:272]);
					check_field("entry_count", e.entry_count, m_axis_tdata[294:288]);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic queue_beat(thl_pkg::action_t act, logic [62:0] st, logic [15:0] par,
			logic [63:0] dat, bit hold = 0);
		req_t q;
		q = '{act, st, par, dat, hold};
		pending_beats.push_back(q);
	endtask

	task automatic wait_quiet();
		wait (pending_beats.size() == 0 && expected_results.size() == 0 && !s_axis_tvalid);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_age(logic [62:0] v);
		wait_quiet();
		@(posedge clk);
		max_age_we <= 1'b1;
		max_age_wdata <= v;
		@(posedge clk);
		max_age_we <= 1'b0;
		model_age = v;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly advancing stamps near a moving "now", with noise and repeats
	task automatic queue_random(int n, logic [62:0] base, int unsigned step, int hold_pct);
		logic [62:0] now, st;
		logic [15:0] par;
		int pick;
		now = base;
		for (int c = 0; c < n; c++) begin
			pick = $urandom_range(0, 99);
			par = ($urandom_range(0, 99) < 75) ? 16'($urandom_range(0, 1)) : 16'($urandom);
			if (pick < 48) begin
				if ($urandom_range(0, 99) < 65) begin
					now = now + 63'($urandom_range(1, step));
					st = now;
				end else if ($urandom_range(0, 99) < 50 && recent_stamps.size() > 0) begin
					st = recent_stamps[$urandom_range(0, recent_stamps.size() - 1)];
				end else if ($urandom_range(0, 99) < 85) begin
					st = now - 63'(64'($urandom_range(0, step)) * 64'($urandom_range(0, 70)));
				end else begin
					st = 63'(rand64());
				end
				recent_stamps.push_back(st);
				if (recent_stamps.size() > 24) void'(recent_stamps.pop_front());
				queue_beat(thl_pkg::ACT_INSERT, st, par, rand64(),
					$urandom_range(0, 99) < hold_pct);
			end else if (pick < 95) begin
				pick = $urandom_range(0, 99);
				if (pick < 30 && recent_stamps.size() > 0)
					st = recent_stamps[$urandom_range(0, recent_stamps.size() - 1)];
				else if (pick < 38)
					st = '0;
				else if (pick < 90)
					st = now - 63'(64'($urandom_range(0, step)) * 64'($urandom_range(0, 70)));
				else
					st = now + 63'($urandom_range(1, step));
				queue_beat(thl_pkg::ACT_LOOKUP, st, 16'($urandom), rand64(),
					$urandom_range(0, 99) < hold_pct);
			end else if (pick < 98) begin
				queue_beat(thl_pkg::ACT_CLEAR, 63'(rand64()), 16'($urandom), rand64());
			end else begin
				queue_beat(thl_pkg::ACT_NONE, 63'(rand64()), 16'($urandom), rand64());
			end
		end
	endtask

	// stimulus phases
	initial begin
		logic [62:0] hi_base;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every action and each lookup case
		queue_beat(thl_pkg::ACT_LOOKUP, 63'd0, 16'd0, 64'd0);
		queue_beat(thl_pkg::ACT_INSERT, 63'd1000, 16'd1, 64'h1111);
		queue_beat(thl_pkg::ACT_LOOKUP, 63'd1000, 16'd0, 64'd0);
		queue_beat(thl_pkg::ACT_LOOKUP, 63'd999, 16'd0, 64'd0);
		queue_beat(thl_pkg::ACT_LOOKUP, 63'd0, 16'd0, 64'd0);
		queue_beat(thl_pkg::ACT_INSERT, 63'd1000, 16'd1, 64'h2222);
		queue_beat(thl_pkg::ACT_INSERT, 63'd3000, 16'd1, 64'h3333);
		queue_beat(thl_pkg::ACT_LOOKUP, 63'd2000, 16'd0, 64'd0);
		queue_beat(thl_pkg::ACT_INSERT, 63'd2000, 16'd2, 64'h4444);
		queue_beat(thl_pkg::ACT_LOOKUP, 63'd2500, 16'd0, 64'd0);
		queue_beat(thl_pkg::ACT_LOOKUP, 63'd2000, 16'd0, 64'd0);
		queue_beat(thl_pkg::ACT_LOOKUP, 63'd1500, 16'd0, 64'd0);
		queue_beat(thl_pkg::ACT_LOOKUP, 63'd3000, 16'd0, 64'd0);
		queue_beat(thl_pkg::ACT_LOOKUP, 63'd1000, 16'd0, 64'd0);
		queue_beat(thl_pkg::ACT_LOOKUP, 63'd4000, 16'd0, 64'd0);
		queue_beat(thl_pkg::ACT_LOOKUP, 63'd500, 16'd0, 64'd0);
		queue_beat(thl_pkg::ACT_INSERT, 63'd0, 16'd1, 64'd0, 1);
		queue_beat(thl_pkg::ACT_INSERT, STAMP_MAX, 16'hFFFF, {64{1'b1}});
		queue_beat(thl_pkg::ACT_INSERT, 63'd5, 16'd0, 64'd5);
		queue_beat(thl_pkg::ACT_LOOKUP, 63'd0, 16'd0, 64'd0);
		queue_beat(thl_pkg::ACT_LOOKUP, STAMP_MAX, 16'd0, 64'd0);
		queue_beat(thl_pkg::ACT_NONE, STAMP_MAX, 16'hFFFF, {64{1'b1}});
		queue_beat(thl_pkg::ACT_CLEAR, 63'd0, 16'd0, 64'd0);
		queue_beat(thl_pkg::ACT_LOOKUP, 63'd1, 16'd0, 64'd0);

		// default age: about a hundred stamps fit, so the buffer overflows
		queue_random(500, 63'd1000000, 200000000, 2);

		// zero age: every insert prunes all older entries
		write_age('0);
		queue_random(200, 63'(rand64() >> 2), 50, 0);

		// widest age, no idling, high stamps
		write_age(STAMP_MAX);
		calm = 1;
		hi_base = 63'(rand64()) | (63'd1 << 62);
		hi_base[61:40] = '0;
		queue_random(400, hi_base, 100000, 3);
		wait_quiet();
		calm = 0;

		// short age with fine steps
		write_age(63'd1000);
		queue_random(350, 63'd77777, 300, 4);

		write_age(thl_pkg::MAX_AGE_RST);
		queue_random(200, 63'd5000, 100000000, 1);

		wait_quiet();
		if (fails == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/thl_pkg.sv
rtl/thl_div.sv
rtl/timestamped_history_lookup.sv
sim/timestamped_history_lookup_test.sv
